### rtl/ttip_pkg.sv
// ----------------------------------------------------------------------------
// ttip_pkg
// shared types and constants for the text to integer parser
// ----------------------------------------------------------------------------
package ttip_pkg;

  // character codes
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] ChLowerX  = 8'h78;
  localparam logic [7:0] ChUpperX  = 8'h58;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;

  // bases
  localparam logic [5:0] BaseAuto  = 6'd0;
  localparam logic [5:0] BaseOct   = 6'd8;
  localparam logic [5:0] BaseDec   = 6'd10;
  localparam logic [5:0] BaseHex   = 6'd16;
  localparam logic [5:0] BaseMax   = 6'd36;
  localparam logic [5:0] RadixReset = 6'd10;

  // digit code for a byte that is no digit at all
  localparam logic [5:0] NoDigit   = 6'd63;

  localparam logic [62:0] MagMax   = {63{1'b1}};

  // fifo between classifier and parser
  localparam int QueueDepth = 2;

  // one classified byte
  typedef struct packed {
    logic       blank;
    logic       minus;
    logic       zero;
    logic       ex;
    logic [5:0] digit;
    logic       last;
  } ttip_item_t;

  // saturating increment of a position or count
  function automatic logic [15:0] bump(input logic [15:0] v, input logic [15:0] lim);
    bump = (v < lim) ? v + 16'd1 : v;
  endfunction

endpackage

### rtl/text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// text_to_integer_parser
// streaming strtol-style integer parse, one text byte per beat
// ----------------------------------------------------------------------------
// Input beats carry text_byte and final_byte on in_valid/in_ready. Leading
// whitespace is skipped, an optional minus is taken, and digits of the
// configured radix (0 selects octal, hex or decimal from the prefix) are
// accumulated up to the first non-digit. On the beat marked final_byte one
// result beat leaves on out_valid/out_ready with the value, span and flags.
// The radix register is written through cfg_valid/cfg_ready/radix, which is
// always ready; it is sampled at the first non-blank byte of each text.
// Throughput is one byte per cycle, barring a final byte held for out_ready:
// the parser applies one 63x6 multiply and add per byte. A byte is classified
// on entry and sits in a two-entry fifo; the last byte's pop loads the result.
// While a result waits on out_ready, bytes of the next text keep flowing
// until that text's final byte reaches the head of the fifo.
// Reset (rst, synchronous) empties the fifo, drops any pending result,
// clears the parse state and sets the radix to 10.
// ----------------------------------------------------------------------------
module text_to_integer_parser import ttip_pkg::*; #(
  parameter longint unsigned MAX_TEXT_LENGTH = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         radix,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               final_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] parsed_value,
  output logic [15:0]        span_start,
  output logic [15:0]        span_length,
  output logic               span_found,
  output logic               overflowed
);

  logic [5:0]  radix_reg;
  ttip_item_t  in_item;
  ttip_item_t  head_item;
  logic        q_full, q_empty, q_pop;

  // radix register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg <= RadixReset;
    end else if (cfg_valid) begin
      radix_reg <= radix;
    end
  end

  assign in_ready = !q_full;

  // byte classifier
  ttip_front u_front (
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .item       (in_item)
  );

  // decoupling fifo
  ttip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_item),
    .empty     (q_empty)
  );

  // parse sequencer
  ttip_back #(
    .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .radix        (radix_reg),
    .item_avail   (!q_empty),
    .item         (head_item),
    .item_pop     (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .span_start   (span_start),
    .span_length  (span_length),
    .span_found   (span_found),
    .overflowed   (overflowed)
  );

endmodule

### rtl/ttip_front.sv
// ----------------------------------------------------------------------------
// ttip_front
// classifies each text byte: whitespace, sign, prefix characters, digit value
// ----------------------------------------------------------------------------
module ttip_front import ttip_pkg::*; (
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output ttip_item_t item
);

  logic [5:0] digit;

  // digit value over 0-9, a-z, A-Z
  always_comb begin
    digit = NoDigit;
    if (text_byte >= ChZero && text_byte <= ChNine) begin
      digit = 6'(text_byte - ChZero);
    end else if (text_byte >= ChUpperA && text_byte <= ChUpperZ) begin
      digit = 6'(text_byte - ChUpperA) + BaseDec;
    end else if (text_byte >= ChLowerA && text_byte <= ChLowerZ) begin
      digit = 6'(text_byte - ChLowerA) + BaseDec;
    end
  end

  // character class flags
  assign item.blank = (text_byte == ChSpace) || (text_byte >= ChTab && text_byte <= ChCr);
  assign item.minus = (text_byte == ChMinus);
  assign item.zero  = (text_byte == ChZero);
  assign item.ex    = (text_byte == ChLowerX) || (text_byte == ChUpperX);
  assign item.digit = digit;
  assign item.last  = final_byte;

endmodule

### rtl/ttip_queue.sv
// ----------------------------------------------------------------------------
// ttip_queue
// short fifo of classified bytes between classifier and parser
// ----------------------------------------------------------------------------
module ttip_queue import ttip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ttip_item_t push_data,
  output logic       full,
  input  logic       pop,
  output ttip_item_t pop_data,
  output logic       empty
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  ttip_item_t            slots [QueueDepth];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;

  assign full     = (count == CntW'(QueueDepth));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/ttip_back.sv
// ----------------------------------------------------------------------------
// ttip_back
// parse sequencer: sign, base prefix, digit accumulation, result register
// ----------------------------------------------------------------------------
module ttip_back import ttip_pkg::*; #(
  parameter longint unsigned MAX_TEXT_LENGTH = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [5:0]        radix,
  input  logic              item_avail,
  input  ttip_item_t        item,
  output logic              item_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [63:0] parsed_value,
  output logic [15:0]       span_start,
  output logic [15:0]       span_length,
  output logic              span_found,
  output logic              overflowed
);

  localparam logic [15:0] CountLimit =
    ((MAX_TEXT_LENGTH - 1) > 65535) ? 16'hFFFF : 16'(MAX_TEXT_LENGTH - 1);

  typedef enum logic [2:0] {
    PH_SPACE, PH_BASE, PH_ZERO, PH_DIGITS, PH_DONE, PH_BAD
  } phase_t;

  phase_t      phase, phase_next;
  logic [62:0] acc, acc_next;
  logic        neg, neg_next;
  logic [5:0]  base, base_next;
  logic [15:0] pos;
  logic [15:0] start, start_next;
  logic [15:0] cnt, cnt_next;
  logic        sat, sat_next;

  logic        go_base, go_digits;
  logic [68:0] prod;
  logic [68:0] sum;
  logic        found;

  // a last byte needs the result register free
  assign item_pop = item_avail && (!item.last || !out_valid || out_ready);

  // next parse state for the byte at the head of the queue
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    neg_next   = neg;
    base_next  = base;
    start_next = start;
    cnt_next   = cnt;
    sat_next   = sat;
    go_base    = 1'b0;
    go_digits  = 1'b0;
    prod       = '0;
    sum        = '0;

    unique case (phase)
      PH_SPACE: begin
        if (!item.blank) begin
          start_next = pos;
          base_next  = radix;
          if (radix > BaseMax) begin
            phase_next = PH_BAD;
          end else begin
            phase_next = PH_BASE;
            if (item.minus) begin
              neg_next = 1'b1;
              cnt_next = bump(cnt, CountLimit);
            end else begin
              go_base = 1'b1;
            end
          end
        end
      end
      PH_BASE: go_base = 1'b1;
      PH_ZERO: begin
        phase_next = PH_DIGITS;
        if (item.ex) begin
          cnt_next  = bump(cnt, CountLimit);
          base_next = BaseHex;
        end else begin
          go_digits = 1'b1;
        end
      end
      PH_DIGITS: go_digits = 1'b1;
      PH_DONE, PH_BAD: ;
      default: ;
    endcase

    // automatic base: leading zero means octal or a hex prefix
    if (go_base) begin
      if (base_next == BaseAuto && item.zero) begin
        cnt_next   = bump(cnt_next, CountLimit);
        base_next  = BaseOct;
        phase_next = PH_ZERO;
      end else begin
        if (base_next == BaseAuto) begin
          base_next = BaseDec;
        end
        phase_next = PH_DIGITS;
        go_digits  = 1'b1;
      end
    end

    // digit step: acc * base + digit, saturate past the magnitude limit
    if (go_digits) begin
      prod = 69'(acc) * 69'(base_next);
      sum  = prod + 69'(item.digit);
      if (item.digit >= base_next) begin
        phase_next = PH_DONE;
      end else if (sum > 69'(MagMax)) begin
        acc_next   = MagMax;
        sat_next   = 1'b1;
        phase_next = PH_DONE;
      end else begin
        acc_next = sum[62:0];
        cnt_next = bump(cnt_next, CountLimit);
      end
    end

    found = (phase_next != PH_SPACE) && (phase_next != PH_BAD) &&
            (cnt_next > {15'd0, neg_next});
  end

  // parse state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SPACE;
      acc       <= '0;
      neg       <= 1'b0;
      base      <= '0;
      pos       <= '0;
      start     <= '0;
      cnt       <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result held until taken, reloaded by a last byte
      out_valid <= (out_valid && !out_ready) || (item_pop && item.last);
      if (item_pop) begin
        if (item.last) begin
          span_found   <= found;
          parsed_value <= !found ? '0 :
                          neg_next ? 64'sd0 - $signed({1'b0, acc_next}) :
                                     $signed({1'b0, acc_next});
          span_start   <= found ? start_next : '0;
          span_length  <= found ? cnt_next : '0;
          overflowed   <= found && sat_next;
          phase <= PH_SPACE;
          acc   <= '0;
          neg   <= 1'b0;
          base  <= '0;
          pos   <= '0;
          start <= '0;
          cnt   <= '0;
          sat   <= 1'b0;
        end else begin
          phase <= phase_next;
          acc   <= acc_next;
          neg   <= neg_next;
          base  <= base_next;
          pos   <= bump(pos, CountLimit);
          start <= start_next;
          cnt   <= cnt_next;
          sat   <= sat_next;
        end
      end
    end
  end

endmodule
